FILE: hdl/tdsgr_pkg.sv
// tdsgr_pkg: shared constants, state codes and arithmetic helpers for the
// two-digit segment grid renderer
// depends on nothing
`timescale 1ns / 1ps

package tdsgr_pkg;

    // sizes
    localparam int LED_COUNT  = 64;
    localparam int LED_W      = $clog2(LED_COUNT);
    localparam int EMIT_W     = $clog2(LED_COUNT + 1);
    localparam int GRID_CELLS = 256;
    localparam int CELL_W     = $clog2(GRID_CELLS);
    localparam int COLOR_W    = 24;
    localparam int DIM_W      = 5;
    localparam int HALF_W     = DIM_W - 1;
    localparam int SEG_W      = 7;
    localparam int ROWBASE_W  = 10;
    localparam int CELLSUM_W  = ROWBASE_W + 1;
    localparam int CFG_IDX_W  = 2;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_ROWS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_COLS = 2'd1;

    // register reset values
    localparam logic [DIM_W-1:0] ROWS_RESET = 5'd5;
    localparam logic [DIM_W-1:0] COLS_RESET = 5'd16;

    // item modes
    localparam logic MODE_LOAD   = 1'b0;
    localparam logic MODE_RENDER = 1'b1;

    // control states, one-hot
    typedef enum logic [5:0] {
        ST_CLEAR = 6'b000001,
        ST_IDLE  = 6'b000010,
        ST_FILL  = 6'b000100,
        ST_WALK  = 6'b001000,
        ST_DRAIN = 6'b010000,
        ST_EMIT  = 6'b100000
    } state_t;

    // segment pattern of one decimal digit, bit0 top .. bit6 bottom
    function automatic logic [SEG_W-1:0] seg_mask(input logic [3:0] digit);
        logic [SEG_W-1:0] m;
        unique case (digit)
            4'd0:    m = 7'h77;
            4'd1:    m = 7'h24;
            4'd2:    m = 7'h5D;
            4'd3:    m = 7'h6D;
            4'd4:    m = 7'h2E;
            4'd5:    m = 7'h6B;
            4'd6:    m = 7'h7B;
            4'd7:    m = 7'h27;
            4'd8:    m = 7'h7F;
            4'd9:    m = 7'h6F;
            default: m = 7'h00;
        endcase
        return m;
    endfunction

    // w / 3 for w in 0..15, reciprocal multiply
    function automatic logic [2:0] div3_4b(input logic [3:0] w);
        logic [8:0] p;
        p = 9'(w) * 9'd11;
        return p[7:5];
    endfunction

    // r / 5 for r in 0..31, reciprocal multiply
    function automatic logic [2:0] div5_5b(input logic [4:0] r);
        logic [9:0] p;
        p = 10'(r) * 10'd13;
        return p[8:6];
    endfunction

    // n / 10 for n in 0..255, reciprocal multiply
    function automatic logic [4:0] div10_8b(input logic [7:0] n);
        logic [15:0] p;
        p = 16'(n) * 16'd205;
        return p[15:11];
    endfunction

endpackage

FILE: hdl/two_digit_segment_grid_renderer.sv
// two_digit_segment_grid_renderer: draws a two-digit number as seven-segment
// glyphs on an LED grid and streams out the LED colors
// depends on tdsgr_pkg
`timescale 1ns / 1ps

// cfg channel (cfg_valid/cfg_ready, cfg_index, cfg_data): index 0 sets the grid
// rows, index 1 the grid columns; other indexes are dropped. cfg_ready is always
// high; write only while the block is idle.
// in channel (in_valid/in_ready): mode 0 writes one cell-to-LED map entry and
// produces no result; mode 1 renders number with the three colors. in_ready is
// high only while no item is in work.
// out channel (out_valid/out_ready): a render produces 64 items, LED 0 to 63,
// with last on LED 63.
// timing: a render fills all 64 LEDs with the background color, then walks both
// digit areas cell by cell, tens area first (a map read for each lit cell inside
// the map; an empty area reads no cells), then passes a drain state and a color
// read, then sends one LED per cycle while out_ready stays high. The walk is
// bounded by the map read port.
// reset: rst_n low clears the control state and sets rows 5 and columns 16. After
// reset a clearing pass marks all 256 map entries invalid; in_ready stays low
// during it (config writes are still taken).
// stall: a stalled out_ready holds the current LED item; the next LED is read
// from the color memory only as the current one leaves.

module two_digit_segment_grid_renderer (
    input  logic                                  clk,
    input  logic                                  rst_n,
    // configuration
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [tdsgr_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [tdsgr_pkg::DIM_W-1:0]           cfg_data,
    // input items
    input  logic                                  in_valid,
    output logic                                  in_ready,
    input  logic                                  mode,
    input  logic [tdsgr_pkg::CELL_W-1:0]          cell_req,
    input  logic [tdsgr_pkg::LED_W-1:0]           led_index,
    input  logic                                  cell_valid,
    input  logic [7:0]                            number,
    input  logic [tdsgr_pkg::COLOR_W-1:0]         high_color,
    input  logic [tdsgr_pkg::COLOR_W-1:0]         low_color,
    input  logic [tdsgr_pkg::COLOR_W-1:0]         back_color,
    // result items
    output logic                                  out_valid,
    input  logic                                  out_ready,
    output logic [tdsgr_pkg::LED_W-1:0]           led,
    output logic [tdsgr_pkg::COLOR_W-1:0]         color,
    output logic                                  last
);

    // ------------------------------------------------------------------
    // declarations
    // ------------------------------------------------------------------
    tdsgr_pkg::state_t state_reg, state_next;

    logic [tdsgr_pkg::DIM_W-1:0]     rows_reg, rows_next;
    logic [tdsgr_pkg::DIM_W-1:0]     cols_reg, cols_next;

    logic [tdsgr_pkg::CELL_W-1:0]    clr_cnt_reg, clr_cnt_next;
    logic [tdsgr_pkg::LED_W-1:0]     fill_cnt_reg, fill_cnt_next;
    logic                            pass_reg, pass_next;
    logic [tdsgr_pkg::DIM_W-1:0]     row_reg, row_next;
    logic [tdsgr_pkg::HALF_W-1:0]    x_reg, x_next;
    logic [tdsgr_pkg::ROWBASE_W-1:0] row_base_reg, row_base_next;
    logic                            draw_pend_reg, draw_pend_next;
    logic [tdsgr_pkg::EMIT_W-1:0]    emit_cnt_reg, emit_cnt_next;
    logic                            out_valid_reg, out_valid_next;

    // item payload, no reset
    logic [tdsgr_pkg::COLOR_W-1:0]   high_reg, low_reg, back_reg;
    logic [4:0]                      quot_reg;
    logic [3:0]                      units_reg;
    logic [tdsgr_pkg::SEG_W-1:0]     seg_hi_reg, seg_lo_reg;
    logic [tdsgr_pkg::COLOR_W-1:0]   draw_color_reg;
    logic [tdsgr_pkg::LED_W-1:0]     led_reg;
    logic                            last_reg;

    // band geometry, registered during the fill
    logic [tdsgr_pkg::HALF_W-1:0]    w_reg;
    logic [2:0]                      cw_reg;
    logic [tdsgr_pkg::HALF_W-1:0]    rb_reg;
    logic [tdsgr_pkg::DIM_W-1:0]     r1_reg, r2_reg, r3_reg, r4_reg;

    // memories
    logic [tdsgr_pkg::LED_W:0]       map_mem [tdsgr_pkg::GRID_CELLS];
    logic [tdsgr_pkg::LED_W:0]       map_rd_reg;
    logic [tdsgr_pkg::COLOR_W-1:0]   pix_mem [tdsgr_pkg::LED_COUNT];
    logic [tdsgr_pkg::COLOR_W-1:0]   pix_rd_reg;

    logic                            map_we, map_re;
    logic [tdsgr_pkg::CELL_W-1:0]    map_waddr, map_raddr;
    logic [tdsgr_pkg::LED_W:0]       map_wdata;
    logic                            pix_we, pix_re;
    logic [tdsgr_pkg::LED_W-1:0]     pix_waddr, pix_raddr;
    logic [tdsgr_pkg::COLOR_W-1:0]   pix_wdata;

    logic                            in_accept, out_accept, cfg_accept;

    // geometry math
    logic [tdsgr_pkg::HALF_W-1:0]    w_calc;
    logic [2:0]                      cw_calc;
    logic [2:0]                      h_calc;
    logic [tdsgr_pkg::DIM_W-1:0]     h5_calc;
    logic [2:0]                      a_calc;
    logic [tdsgr_pkg::DIM_W-1:0]     r1_calc, r2_calc, r3_calc, r4_calc;
    logic [4:0]                      quot_calc;
    logic [7:0]                      quot_x10;
    logic [3:0]                      tens_calc;

    // walk datapath
    logic                            degenerate;
    logic [tdsgr_pkg::HALF_W-1:0]    x_off;
    logic [tdsgr_pkg::CELLSUM_W-1:0] cell_sum;
    logic                            cell_in_map;
    logic [tdsgr_pkg::SEG_W-1:0]     seg_cur;
    logic                            in_left, in_right;
    logic                            above_r1, above_r3, from_r2, from_r4;
    logic                            lit;
    logic                            x_at_end, row_at_end, pass_end;

    // emit datapath
    logic                            emit_more, rd_issue;

    // ------------------------------------------------------------------
    // handshakes
    // ------------------------------------------------------------------
    assign cfg_ready  = 1'b1;
    assign in_ready   = (state_reg == tdsgr_pkg::ST_IDLE);
    assign cfg_accept = cfg_valid && cfg_ready;
    assign in_accept  = in_valid && in_ready;
    assign out_accept = out_valid_reg && out_ready;

    assign out_valid = out_valid_reg;
    assign led       = led_reg;
    assign color     = pix_rd_reg;
    assign last      = last_reg;

    // ------------------------------------------------------------------
    // geometry: digit width cols/2, column bands w/3 with remainder in the
    // middle, row bands rows/5 with the remainder spread lower, upper, middle, bottom, not to the top
    // ------------------------------------------------------------------
    always_comb
    begin
        w_calc   = cols_reg[tdsgr_pkg::DIM_W-1:1];
        cw_calc  = tdsgr_pkg::div3_4b(w_calc);
        h_calc   = tdsgr_pkg::div5_5b(rows_reg);
        h5_calc  = {h_calc, 2'b00} + 5'(h_calc);
        a_calc   = 3'(rows_reg - h5_calc);
        r1_calc  = 5'(h_calc);
        r2_calc  = r1_calc + 5'(h_calc) + 5'(a_calc > 3'd1);
        r3_calc  = r2_calc + 5'(h_calc) + 5'(a_calc > 3'd2);
        r4_calc  = r3_calc + 5'(h_calc) + 5'(a_calc > 3'd0);
        // tens digit: quotient of number/10 is at most 25
        if (quot_reg >= 5'd20)
        begin
            tens_calc = 4'(quot_reg - 5'd20);
        end
        else if (quot_reg >= 5'd10)
        begin
            tens_calc = 4'(quot_reg - 5'd10);
        end
        else
        begin
            tens_calc = quot_reg[3:0];
        end
        quot_calc = tdsgr_pkg::div10_8b(number);
        quot_x10  = {quot_calc, 3'b000} + {2'b00, quot_calc, 1'b0};
    end

    // ------------------------------------------------------------------
    // cell walk: one grid cell per cycle, tens area first then units area
    // ------------------------------------------------------------------
    always_comb
    begin
        degenerate  = (rows_reg == '0) || (w_reg == '0);
        x_off       = pass_reg ? w_reg : '0;
        cell_sum    = tdsgr_pkg::CELLSUM_W'(row_base_reg) + tdsgr_pkg::CELLSUM_W'(x_off)
                    + tdsgr_pkg::CELLSUM_W'(x_reg);
        cell_in_map = (cell_sum < tdsgr_pkg::CELLSUM_W'(tdsgr_pkg::GRID_CELLS));
        seg_cur     = pass_reg ? seg_lo_reg : seg_hi_reg;
        in_left     = (x_reg < 4'(cw_reg));
        in_right    = (x_reg >= rb_reg);
        above_r1    = (row_reg < r1_reg);
        above_r3    = (row_reg < r3_reg);
        from_r2     = (row_reg >= r2_reg);
        from_r4     = (row_reg >= r4_reg);
        lit         = (seg_cur[0] && above_r1)
                   || (seg_cur[1] && in_left && above_r3)
                   || (seg_cur[2] && in_right && above_r3)
                   || (seg_cur[3] && from_r2 && above_r3)
                   || (seg_cur[4] && in_left && from_r2)
                   || (seg_cur[5] && in_right && from_r2)
                   || (seg_cur[6] && from_r4);
        x_at_end    = (x_reg == w_reg - 4'd1);
        row_at_end  = (row_reg == rows_reg - 5'd1);
        pass_end    = degenerate || (x_at_end && row_at_end);
    end

    // ------------------------------------------------------------------
    // emit: the color memory read register is the output data register
    // ------------------------------------------------------------------
    assign emit_more = (emit_cnt_reg < tdsgr_pkg::EMIT_W'(tdsgr_pkg::LED_COUNT));
    assign rd_issue  = (state_reg == tdsgr_pkg::ST_EMIT) && emit_more
                    && (!out_valid_reg || out_ready);

    // ------------------------------------------------------------------
    // memory port muxing
    // ------------------------------------------------------------------
    always_comb
    begin
        // map: cleared after reset, loaded by mode 0 items, read by the walk
        if (state_reg == tdsgr_pkg::ST_CLEAR)
        begin
            map_we    = 1'b1;
            map_waddr = clr_cnt_reg;
            map_wdata = '0;
        end
        else
        begin
            map_we    = in_accept && (mode == tdsgr_pkg::MODE_LOAD);
            map_waddr = cell_req;
            map_wdata = {cell_valid, led_index};
        end
        map_re    = (state_reg == tdsgr_pkg::ST_WALK) && !degenerate && lit && cell_in_map;
        map_raddr = cell_sum[tdsgr_pkg::CELL_W-1:0];

        // colors: background fill, then digit writes in the cycle after the map read
        if (state_reg == tdsgr_pkg::ST_FILL)
        begin
            pix_we    = 1'b1;
            pix_waddr = fill_cnt_reg;
            pix_wdata = back_reg;
        end
        else
        begin
            pix_we    = draw_pend_reg && map_rd_reg[tdsgr_pkg::LED_W];
            pix_waddr = map_rd_reg[tdsgr_pkg::LED_W-1:0];
            pix_wdata = draw_color_reg;
        end
        pix_re    = rd_issue;
        pix_raddr = emit_cnt_reg[tdsgr_pkg::LED_W-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (map_we)
        begin
            map_mem[map_waddr] <= map_wdata;
        end
        if (map_re)
        begin
            map_rd_reg <= map_mem[map_raddr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (pix_we)
        begin
            pix_mem[pix_waddr] <= pix_wdata;
        end
        if (pix_re)
        begin
            pix_rd_reg <= pix_mem[pix_raddr];
        end
    end

    // ------------------------------------------------------------------
    // sequencer
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next     = state_reg;
        rows_next      = rows_reg;
        cols_next      = cols_reg;
        clr_cnt_next   = clr_cnt_reg;
        fill_cnt_next  = fill_cnt_reg;
        pass_next      = pass_reg;
        row_next       = row_reg;
        x_next         = x_reg;
        row_base_next  = row_base_reg;
        draw_pend_next = map_re;
        emit_cnt_next  = emit_cnt_reg;
        out_valid_next = out_valid_reg;

        if (cfg_accept)
        begin
            case (cfg_index)
                tdsgr_pkg::CFG_ROWS: rows_next = cfg_data;
                tdsgr_pkg::CFG_COLS: cols_next = cfg_data;
                default:             ;
            endcase
        end

        if (rd_issue)
        begin
            out_valid_next = 1'b1;
            emit_cnt_next  = emit_cnt_reg + 7'd1;
        end
        else if (out_accept)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            tdsgr_pkg::ST_CLEAR:
            begin
                clr_cnt_next = clr_cnt_reg + 8'd1;
                if (clr_cnt_reg == tdsgr_pkg::CELL_W'(tdsgr_pkg::GRID_CELLS - 1))
                begin
                    state_next = tdsgr_pkg::ST_IDLE;
                end
            end
            tdsgr_pkg::ST_IDLE:
            begin
                if (in_accept && (mode == tdsgr_pkg::MODE_RENDER))
                begin
                    fill_cnt_next = '0;
                    state_next    = tdsgr_pkg::ST_FILL;
                end
            end
            tdsgr_pkg::ST_FILL:
            begin
                fill_cnt_next = fill_cnt_reg + 6'd1;
                if (fill_cnt_reg == tdsgr_pkg::LED_W'(tdsgr_pkg::LED_COUNT - 1))
                begin
                    pass_next     = 1'b0;
                    row_next      = '0;
                    x_next        = '0;
                    row_base_next = '0;
                    state_next    = tdsgr_pkg::ST_WALK;
                end
            end
            tdsgr_pkg::ST_WALK:
            begin
                if (pass_end)
                begin
                    row_next      = '0;
                    x_next        = '0;
                    row_base_next = '0;
                    if (pass_reg)
                    begin
                        state_next = tdsgr_pkg::ST_DRAIN;
                    end
                    else
                    begin
                        pass_next = 1'b1;
                    end
                end
                else if (x_at_end)
                begin
                    x_next        = '0;
                    row_next      = row_reg + 5'd1;
                    row_base_next = row_base_reg + tdsgr_pkg::ROWBASE_W'(cols_reg);
                end
                else
                begin
                    x_next = x_reg + 4'd1;
                end
            end
            tdsgr_pkg::ST_DRAIN:
            begin
                // last digit write lands this cycle
                emit_cnt_next = '0;
                state_next    = tdsgr_pkg::ST_EMIT;
            end
            tdsgr_pkg::ST_EMIT:
            begin
                if (!emit_more && (!out_valid_reg || out_ready))
                begin
                    state_next = tdsgr_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = tdsgr_pkg::ST_CLEAR;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= tdsgr_pkg::ST_CLEAR;
            rows_reg      <= tdsgr_pkg::ROWS_RESET;
            cols_reg      <= tdsgr_pkg::COLS_RESET;
            clr_cnt_reg   <= '0;
            fill_cnt_reg  <= '0;
            pass_reg      <= 1'b0;
            row_reg       <= '0;
            x_reg         <= '0;
            row_base_reg  <= '0;
            draw_pend_reg <= 1'b0;
            emit_cnt_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rows_reg      <= rows_next;
            cols_reg      <= cols_next;
            clr_cnt_reg   <= clr_cnt_next;
            fill_cnt_reg  <= fill_cnt_next;
            pass_reg      <= pass_next;
            row_reg       <= row_next;
            x_reg         <= x_next;
            row_base_reg  <= row_base_next;
            draw_pend_reg <= draw_pend_next;
            emit_cnt_reg  <= emit_cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            high_reg  <= high_color;
            low_reg   <= low_color;
            back_reg  <= back_color;
            quot_reg  <= quot_calc;
            units_reg <= 4'(number - quot_x10);
        end
        if (state_reg == tdsgr_pkg::ST_FILL)
        begin
            seg_hi_reg <= tdsgr_pkg::seg_mask(tens_calc);
            seg_lo_reg <= tdsgr_pkg::seg_mask(units_reg);
            w_reg      <= w_calc;
            cw_reg     <= cw_calc;
            rb_reg     <= w_calc - 4'(cw_calc);
            r1_reg     <= r1_calc;
            r2_reg     <= r2_calc;
            r3_reg     <= r3_calc;
            r4_reg     <= r4_calc;
        end
        draw_color_reg <= pass_reg ? low_reg : high_reg;
        if (rd_issue)
        begin
            led_reg  <= emit_cnt_reg[tdsgr_pkg::LED_W-1:0];
            last_reg <= (emit_cnt_reg == tdsgr_pkg::EMIT_W'(tdsgr_pkg::LED_COUNT - 1));
        end
    end

    // ------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------
    a_out_only_emit: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (state_reg == tdsgr_pkg::ST_EMIT))
        else $error("result item shown outside the emit phase");

    a_last_is_final_led: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && last_reg) |->
        (led_reg == tdsgr_pkg::LED_W'(tdsgr_pkg::LED_COUNT - 1)))
        else $error("last marker on an LED other than the final one");

    a_idle_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_ready && last_reg) |=> (state_reg == tdsgr_pkg::ST_IDLE))
        else $error("render did not finish after its last item");

    a_render_starts_fill: assert property (@(posedge clk) disable iff (!rst_n)
        (in_accept && (mode == tdsgr_pkg::MODE_RENDER)) |=>
        (state_reg == tdsgr_pkg::ST_FILL && fill_cnt_reg == '0))
        else $error("render item did not start the background fill");

    a_no_pix_rw_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(pix_we && pix_re))
        else $error("color memory written while emitting");

    a_drain_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == tdsgr_pkg::ST_EMIT) |-> !draw_pend_reg)
        else $error("digit write still pending during emit");

endmodule

FILE: sim/tb_two_digit_segment_grid_renderer.sv
// tb_two_digit_segment_grid_renderer: self-checking bench for the segment grid renderer,
// directed table then random load/render traffic over several grid sizes and idle mixes
// depends on tdsgr_pkg and two_digit_segment_grid_renderer
`timescale 1ns / 1ps

module tb_two_digit_segment_grid_renderer;

    // spare register indexes, the block must drop writes to them
    localparam logic [tdsgr_pkg::CFG_IDX_W-1:0] CFG_SPARE_A = 2'd2;
    localparam logic [tdsgr_pkg::CFG_IDX_W-1:0] CFG_SPARE_B = 2'd3;

    // cycles with no handshake on any channel before the run is declared hung
    // (a 31x31 render walks both digit areas before its first LED)
    localparam int IDLE_LIMIT = 6000;
    localparam int PHASES     = 12;
    localparam int PHASE_ITEMS = 24;

    // segment patterns per digit, bit0 top .. bit6 bottom
    localparam logic [0:9][6:0] SEG_TABLE = {
        7'h77, 7'h24, 7'h5D, 7'h6D, 7'h2E, 7'h6B, 7'h7B, 7'h27, 7'h7F, 7'h6F
    };

    // grid size per phase, the last phase picks its own at random
    localparam logic [0:10][tdsgr_pkg::DIM_W-1:0] PHASE_ROWS = {
        5'd5, 5'd1, 5'd31, 5'd0, 5'd5, 5'd8, 5'd16, 5'd10, 5'd3, 5'd31, 5'd7
    };
    localparam logic [0:10][tdsgr_pkg::DIM_W-1:0] PHASE_COLS = {
        5'd16, 5'd2, 5'd31, 5'd16, 5'd0, 5'd12, 5'd16, 5'd6, 5'd31, 5'd1, 5'd9
    };

    // one input item as driven on the ports
    typedef struct packed {
        logic                          mode;
        logic [tdsgr_pkg::CELL_W-1:0]  cell_pos;
        logic [tdsgr_pkg::LED_W-1:0]   led;
        logic                          ok;
        logic [7:0]                    number;
        logic [tdsgr_pkg::COLOR_W-1:0] high;
        logic [tdsgr_pkg::COLOR_W-1:0] low;
        logic [tdsgr_pkg::COLOR_W-1:0] back;
    } grid_item_t;

    // one LED color item as seen on the output
    typedef struct packed {
        logic [tdsgr_pkg::LED_W-1:0]   led;
        logic [tdsgr_pkg::COLOR_W-1:0] color;
        logic                          last;
    } led_item_t;

    // directed row: bg_only means the whole frame must be the background color
    typedef struct packed {
        grid_item_t item;
        logic       bg_only;
    } dir_step_t;

    logic clk;
    logic rst_n;

    logic                            cfg_valid;
    logic                            cfg_ready;
    logic [tdsgr_pkg::CFG_IDX_W-1:0] cfg_index;
    logic [tdsgr_pkg::DIM_W-1:0]     cfg_data;

    logic                            in_valid;
    logic                            in_ready;
    logic                            mode;
    logic [tdsgr_pkg::CELL_W-1:0]    cell_req;
    logic [tdsgr_pkg::LED_W-1:0]     led_index;
    logic                            cell_valid;
    logic [7:0]                      number;
    logic [tdsgr_pkg::COLOR_W-1:0]   high_color;
    logic [tdsgr_pkg::COLOR_W-1:0]   low_color;
    logic [tdsgr_pkg::COLOR_W-1:0]   back_color;

    logic                            out_valid;
    logic                            out_ready = 1'b0;
    logic [tdsgr_pkg::LED_W-1:0]     led;
    logic [tdsgr_pkg::COLOR_W-1:0]   color;
    logic                            last;

    // bench copy of the block state
    bit                              map_ok  [tdsgr_pkg::GRID_CELLS];
    logic [tdsgr_pkg::LED_W-1:0]     map_led [tdsgr_pkg::GRID_CELLS];
    int                              rows_cfg = tdsgr_pkg::ROWS_RESET;
    int                              cols_cfg = tdsgr_pkg::COLS_RESET;

    // LED colors still owed by the block, oldest first
    led_item_t                       frame_q[$];
    dir_step_t                       dir_rows[$];

    int                              bad_count = 0;
    int                              quiet_cycles = 0;
    int                              send_gap_pct = 0;
    int                              sink_stall_pct = 0;

    two_digit_segment_grid_renderer DUT (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .mode       (mode),
        .cell_req   (cell_req),
        .led_index  (led_index),
        .cell_valid (cell_valid),
        .number     (number),
        .high_color (high_color),
        .low_color  (low_color),
        .back_color (back_color),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .led        (led),
        .color      (color),
        .last       (last)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // receiver backpressure, redrawn every falling edge
    always @(negedge clk)
    begin
        out_ready = ($urandom_range(99) >= sink_stall_pct);
    end

    // is cell (x, y) of a digit w columns wide inside a lit segment
    function automatic bit seg_lit(input logic [6:0] segs, input int w, input int rows,
                                   input int x, input int y);
        int cw, b1, b2, h, a, r1, r2, r3, r4;
        bit on;
        cw = w / 3;
        b1 = cw;
        // middle band takes the column remainder
        b2 = 2 * cw + (w - 3 * cw);
        h  = rows / 5;
        a  = rows % 5;
        r1 = h;
        r2 = r1 + h + ((a > 1) ? 1 : 0);
        r3 = r2 + h + ((a > 2) ? 1 : 0);
        r4 = r3 + h + ((a > 0) ? 1 : 0);
        on = 1'b0;
        if (segs[0] && y < r1)               on = 1'b1;
        if (segs[1] && x < b1 && y < r3)     on = 1'b1;
        if (segs[2] && x >= b2 && y < r3)    on = 1'b1;
        if (segs[3] && y >= r2 && y < r3)    on = 1'b1;
        if (segs[4] && x < b1 && y >= r2)    on = 1'b1;
        if (segs[5] && x >= b2 && y >= r2)   on = 1'b1;
        if (segs[6] && y >= r4)              on = 1'b1;
        return on;
    endfunction

    // paint one frame into a local buffer and queue its 64 LED colors
    function automatic void paint_frame(input grid_item_t it);
        logic [tdsgr_pkg::COLOR_W-1:0] px [tdsgr_pkg::LED_COUNT];
        logic [6:0]                    segs;
        logic [tdsgr_pkg::COLOR_W-1:0] ink;
        led_item_t                     li;
        int                            half, d, x, y, pos, i;
        for (i = 0; i < tdsgr_pkg::LED_COUNT; i++)
            px[i] = it.back;
        half = cols_cfg / 2;
        // tens digit first, units digit paints over shared LEDs
        for (d = 0; d < 2; d++)
        begin
            segs = (d == 0) ? SEG_TABLE[(it.number / 10) % 10] : SEG_TABLE[it.number % 10];
            ink  = (d == 0) ? it.high : it.low;
            for (y = 0; y < rows_cfg; y++)
                for (x = 0; x < half; x++)
                    if (seg_lit(segs, half, rows_cfg, x, y))
                    begin
                        pos = cols_cfg * y + d * half + x;
                        // cells past the map end count as unmapped
                        if (pos < tdsgr_pkg::GRID_CELLS && map_ok[pos])
                            px[map_led[pos]] = ink;
                    end
        end
        for (i = 0; i < tdsgr_pkg::LED_COUNT; i++)
        begin
            li.led   = tdsgr_pkg::LED_W'(i);
            li.color = px[i];
            li.last  = (i == tdsgr_pkg::LED_COUNT - 1);
            frame_q.push_back(li);
        end
    endfunction

    function automatic logic [tdsgr_pkg::COLOR_W-1:0] pick_color();
        case ($urandom_range(9))
            0:       return '0;
            1:       return '1;
            default: return tdsgr_pkg::COLOR_W'($urandom);
        endcase
    endfunction

    // fully random item, any mode, unused fields random too
    function automatic grid_item_t random_item();
        grid_item_t it;
        it.mode     = 1'($urandom_range(1));
        it.cell_pos = tdsgr_pkg::CELL_W'($urandom);
        it.led      = tdsgr_pkg::LED_W'($urandom);
        it.ok       = 1'($urandom_range(1));
        it.number   = ($urandom_range(3) == 0) ? 8'($urandom_range(255, 99))
                                               : 8'($urandom_range(99));
        it.high     = pick_color();
        it.low      = pick_color();
        it.back     = pick_color();
        return it;
    endfunction

    function automatic dir_step_t load_row(input int cell_no, input int led_no, input bit ok);
        dir_step_t s;
        s.item          = '0;
        s.item.mode     = tdsgr_pkg::MODE_LOAD;
        s.item.cell_pos = tdsgr_pkg::CELL_W'(cell_no);
        s.item.led      = tdsgr_pkg::LED_W'(led_no);
        s.item.ok       = ok;
        // fields a load ignores, kept busy
        s.item.number   = 8'h5A;
        s.item.high     = 24'hA5A5A5;
        s.item.low      = 24'h3C3C3C;
        s.item.back     = 24'hC3C3C3;
        s.bg_only       = 1'b0;
        return s;
    endfunction

    function automatic dir_step_t render_row(input int num, input int hi, input int lo,
                                             input int bg, input bit bg_only);
        dir_step_t s;
        s.item          = '0;
        s.item.mode     = tdsgr_pkg::MODE_RENDER;
        s.item.cell_pos = tdsgr_pkg::CELL_W'(8'hC7);
        s.item.led      = tdsgr_pkg::LED_W'(6'h2B);
        s.item.ok       = 1'b1;
        s.item.number   = 8'(num);
        s.item.high     = tdsgr_pkg::COLOR_W'(hi);
        s.item.low      = tdsgr_pkg::COLOR_W'(lo);
        s.item.back     = tdsgr_pkg::COLOR_W'(bg);
        s.bg_only       = bg_only;
        return s;
    endfunction

    // hand one item over, then record what it must cause
    task automatic send_item(input grid_item_t it, input bit bg_only);
        led_item_t li;
        int i;
        @(negedge clk);
        while ($urandom_range(99) < send_gap_pct)
        begin
            in_valid = 1'b0;
            @(negedge clk);
        end
        mode       = it.mode;
        cell_req   = it.cell_pos;
        led_index  = it.led;
        cell_valid = it.ok;
        number     = it.number;
        high_color = it.high;
        low_color  = it.low;
        back_color = it.back;
        in_valid   = 1'b1;
        do @(posedge clk); while (!in_ready);
        if (it.mode == tdsgr_pkg::MODE_LOAD)
        begin
            map_ok[it.cell_pos]  = it.ok;
            map_led[it.cell_pos] = it.led;
        end
        else if (bg_only)
        begin
            // nothing mapped yet, the frame is pure background
            for (i = 0; i < tdsgr_pkg::LED_COUNT; i++)
            begin
                li.led   = tdsgr_pkg::LED_W'(i);
                li.color = it.back;
                li.last  = (i == tdsgr_pkg::LED_COUNT - 1);
                frame_q.push_back(li);
            end
        end
        else
        begin
            paint_frame(it);
        end
    endtask

    task automatic write_reg(input logic [tdsgr_pkg::CFG_IDX_W-1:0] idx,
                             input logic [tdsgr_pkg::DIM_W-1:0] val);
        @(negedge clk);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data  = val;
        do @(posedge clk); while (!cfg_ready);
        if (idx == tdsgr_pkg::CFG_ROWS)
            rows_cfg = val;
        else if (idx == tdsgr_pkg::CFG_COLS)
            cols_cfg = val;
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    // block idle: all frames out, plus room for a trailing map load
    task automatic drain_frames();
        while (frame_q.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    // bursts of map loads into the current grid followed by a render,
    // with some fully random items mixed in
    task automatic run_phase(input int n_items);
        grid_item_t it;
        int sent, burst, k, half, x, y, pos;
        sent = 0;
        while (sent < n_items)
        begin
            if ($urandom_range(99) < 85)
            begin
                burst = $urandom_range(6);
                half  = cols_cfg / 2;
                for (k = 0; k < burst; k++)
                begin
                    it      = random_item();
                    it.mode = tdsgr_pkg::MODE_LOAD;
                    // aim most loads at cells that a digit can reach
                    if (rows_cfg != 0 && half != 0 && $urandom_range(9) != 0)
                    begin
                        y   = $urandom_range(rows_cfg - 1);
                        x   = $urandom_range(2 * half - 1);
                        pos = cols_cfg * y + x;
                        if (pos < tdsgr_pkg::GRID_CELLS)
                            it.cell_pos = tdsgr_pkg::CELL_W'(pos);
                    end
                    it.ok = ($urandom_range(4) != 0);
                    send_item(it, 1'b0);
                    sent++;
                end
                it      = random_item();
                it.mode = tdsgr_pkg::MODE_RENDER;
                send_item(it, 1'b0);
                sent++;
            end
            else
            begin
                send_item(random_item(), 1'b0);
                sent++;
            end
        end
        @(negedge clk);
        in_valid = 1'b0;
    endtask

    // result checker: every LED item against the oldest expectation
    always @(posedge clk)
    begin : check_leds
        led_item_t want;
        led_item_t got;
        if (rst_n && out_valid && out_ready)
        begin
            got.led   = led;
            got.color = color;
            got.last  = last;
            if (frame_q.size() == 0)
            begin
                bad_count++;
                if (bad_count <= 10)
                    $display("%0t: unexpected item led=%0d color=%06h last=%0b",
                             $realtime, got.led, got.color, got.last);
            end
            else
            begin
                want = frame_q.pop_front();
                if (got.led !== want.led || got.color !== want.color ||
                    got.last !== want.last)
                begin
                    bad_count++;
                    if (bad_count <= 10)
                        $display({"%0t: exp led=%0d color=%06h last=%0b, ",
                                  "got led=%0d color=%06h last=%0b"},
                                 $realtime, want.led, want.color, want.last,
                                 got.led, got.color, got.last);
                end
            end
        end
    end

    // hang detection: any handshake resets the count
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= IDLE_LIMIT)
        begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    initial
    begin
        int p, i;
        logic [tdsgr_pkg::DIM_W-1:0] r, c;

        rst_n      = 1'b0;
        cfg_valid  = 1'b0;
        cfg_index  = tdsgr_pkg::CFG_ROWS;
        cfg_data   = '0;
        in_valid   = 1'b0;
        mode       = tdsgr_pkg::MODE_LOAD;
        cell_req   = '0;
        led_index  = '0;
        cell_valid = 1'b0;
        number     = '0;
        high_color = '0;
        low_color  = '0;
        back_color = '0;

        // directed table on the reset grid, 5 rows by 16 columns
        // empty map: every render is background only
        dir_rows.push_back(render_row(0,   'hFFFFFF, 'h000000, 'h123456, 1'b1));
        dir_rows.push_back(render_row(255, 'h000000, 'hFFFFFF, 'hFFFFFF, 1'b1));
        dir_rows.push_back(render_row(99,  'h00FF00, 'hFF0000, 'h000000, 1'b1));
        // map a few cells, lowest and highest cell and LED among them
        dir_rows.push_back(load_row(0,   0,  1'b1));  // tens top-left corner
        dir_rows.push_back(load_row(255, 63, 1'b1));  // below the last grid row
        dir_rows.push_back(load_row(8,   63, 1'b1));  // units top-left corner
        dir_rows.push_back(load_row(17,  5,  1'b1));  // tens upper-left band
        dir_rows.push_back(load_row(33,  6,  1'b1));  // tens middle row, left
        dir_rows.push_back(load_row(79,  62, 1'b1));  // units bottom-right
        dir_rows.push_back(load_row(47,  40, 1'b1));  // units middle, right edge
        dir_rows.push_back(load_row(11,  5,  1'b1));  // units top shares an LED with tens
        // every digit appears in the tens or the units place
        dir_rows.push_back(render_row(88,  'hFFFFFF, 'h0000FF, 'h000000, 1'b0));
        dir_rows.push_back(render_row(0,   'h112233, 'h445566, 'h778899, 1'b0));
        dir_rows.push_back(render_row(1,   'h00FF00, 'hFF0000, 'h0000FF, 1'b0));
        dir_rows.push_back(render_row(23,  'hABCDEF, 'h123456, 'h000000, 1'b0));
        dir_rows.push_back(render_row(45,  'h000000, 'hFFFFFF, 'h808080, 1'b0));
        dir_rows.push_back(render_row(67,  'hFFFFFF, 'h000000, 'h010101, 1'b0));
        dir_rows.push_back(render_row(89,  'h0F0F0F, 'hF0F0F0, 'h00FF00, 1'b0));
        dir_rows.push_back(render_row(100, 'hFF00FF, 'h00FFFF, 'h000000, 1'b0));
        // unmapping cells again
        dir_rows.push_back(load_row(17,  0,  1'b0));
        dir_rows.push_back(load_row(0,   63, 1'b0));
        dir_rows.push_back(render_row(8,   'hFFFFFF, 'hFFFFFF, 'h000000, 1'b0));
        dir_rows.push_back(render_row(70,  'h000000, 'h000000, 'hFFFFFF, 1'b0));

        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed part with no idling; in_ready holds off through the map clear
        for (i = 0; i < dir_rows.size(); i++)
            send_item(dir_rows[i].item, dir_rows[i].bg_only);
        @(negedge clk);
        in_valid = 1'b0;

        for (p = 0; p < PHASES; p++)
        begin
            drain_frames();
            if (p < PHASES - 1)
            begin
                r = PHASE_ROWS[p];
                c = PHASE_COLS[p];
            end
            else
            begin
                r = tdsgr_pkg::DIM_W'($urandom_range(31));
                c = tdsgr_pkg::DIM_W'($urandom_range(31));
            end
            write_reg(tdsgr_pkg::CFG_ROWS, r);
            write_reg(tdsgr_pkg::CFG_COLS, c);
            // writes to unused indexes must not disturb the grid
            if (p % 3 == 1)
                write_reg(CFG_SPARE_A, tdsgr_pkg::DIM_W'($urandom));
            else if (p % 3 == 2)
                write_reg(CFG_SPARE_B, tdsgr_pkg::DIM_W'($urandom));
            case (p % 4)
                0:
                begin
                    send_gap_pct   = 0;
                    sink_stall_pct = 0;
                end
                1:
                begin
                    send_gap_pct   = 78;
                    sink_stall_pct = 0;
                end
                2:
                begin
                    send_gap_pct   = 0;
                    sink_stall_pct = 78;
                end
                default:
                begin
                    send_gap_pct   = 36;
                    sink_stall_pct = 36;
                end
            endcase
            run_phase(PHASE_ITEMS);
        end

        // let the last frame out, then a short quiet tail
        while (frame_q.size() != 0)
            @(posedge clk);
        repeat (16) @(posedge clk);
        if (bad_count == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
